FILE: rtl/kld_pkg.sv
package kld_pkg;

    localparam int LOG_FRAC   = 24;
    localparam int TOTAL_BITS = 48;
    localparam int QUOT_W     = 49;
    localparam int MUL_W      = 32;

    localparam logic [31:0]        LN2_Q32 = 32'd2977044472;
    localparam logic signed [15:0] JAC_ONE = 16'sd4096;

    typedef struct packed {
        logic [16:0]        ref_prob;
        logic [16:0]        warped_prob;
        logic signed [15:0] jacobian;
        logic               in_mask;
        logic [15:0]        timepoint_weight;
        logic               last_of_timepoint;
        logic               last_of_set;
    } kld_in_t;

    typedef struct packed {
        logic signed [47:0] measure_value;
        logic               empty_timepoint;
    } kld_out_t;

    typedef struct packed {
        logic done;
        logic big;
    } kld_div_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOG_NORM,
        ST_LOG_SQ,
        ST_LN_MUL,
        ST_REF_MUL,
        ST_JAC_MUL,
        ST_ACCUM,
        ST_CLOSE,
        ST_PROD_LO,
        ST_PROD_HI,
        ST_DIV_WAIT,
        ST_CLEAR,
        ST_EMIT
    } kld_state_t;

endpackage

FILE: rtl/kl_divergence_measure.sv
// channel   direction  handshake            payload
// in        request    in_valid / in_stall  in_data (kld_in_t)
// out       result     out_valid / out_stall out_data (kld_out_t)
// cfg       write      cfg_valid / cfg_ready cfg_data (jacobian_enable)
//
// a voxel outside the mask or with zero weight goes from the accept straight to the close check
// a counted voxel passes through the accept, two logarithms on the shared 32x32 multiplier,
// up to three scaling products (two with jacobian_enable low), the accumulate and the close check;
// a time-point close adds two product steps, a bit-serial divide and the clear, and at the end of
// a set the result is then handed to the output register
// reset clears all sums and the output valid flag; no pass over memory is needed
// a result waiting under out_stall keeps the block in emit, so the next request waits
module kl_divergence_measure
    import kld_pkg::*;
#(
    parameter int VOXEL_COUNT_BITS = 24,
    parameter int PROB_FRAC_BITS   = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  kld_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output kld_out_t out_data,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data
);

    localparam int XW = PROB_FRAC_BITS + 2;
    localparam int TP = ((32 + VOXEL_COUNT_BITS) > 62) ? 62 : (32 + VOXEL_COUNT_BITS);
    localparam int JS = 16 + VOXEL_COUNT_BITS;
    localparam int PW = TP + 20;
    localparam logic [XW-1:0] PROB_ONE = XW'(1) << PROB_FRAC_BITS;

    kld_state_t state_reg, state_next;

    logic              jac_en_reg, jac_en_next;
    logic [XW-1:0]     r_reg, r_next, w_reg, w_next;
    logic signed [15:0] jac_reg, jac_next;
    logic [15:0]       wt_reg, wt_next;
    logic              ltp_reg, ltp_next, lset_reg, lset_next;
    logic              sel_w_reg, sel_w_next;
    logic [30:0]       m_reg, m_next;
    logic [4:0]        msb_reg, msb_next;
    logic [23:0]       frac_reg, frac_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [28:0]       logr_reg, logr_next;
    logic [28:0]       dmag_reg, dmag_next;
    logic              neg_reg, neg_next;
    logic [29:0]       ln_reg, ln_next;
    logic [33:0]       t_reg, t_next;
    logic signed [TP-1:0] tp_reg, tp_next;
    logic signed [JS-1:0] js_reg, js_next;
    logic signed [47:0]   tot_reg, tot_next;
    logic              empty_reg, empty_next;
    logic [63:0]       plo_reg, plo_next;
    logic              out_valid_reg, out_valid_next;
    kld_out_t          out_reg, out_next;

    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] mul_p;
    logic               div_start;
    logic [PW-1:0]      div_dvd;
    kld_div_status_t    div_stat;
    logic [QUOT_W-1:0]  div_q;

    logic [XW-1:0]  x_sel;
    logic [4:0]     msb_c;
    logic [40:0]    r_wide, w_wide;
    logic [XW-1:0]  r_clip, w_clip;
    logic [31:0]    sq;
    logic [28:0]    logv;
    logic [63:0]    rnd;
    logic [15:0]    jmag;
    logic [TP-1:0]  tm;
    logic [JS-1:0]  jm;
    logic [19:0]    bw;
    logic signed [TP:0] tp_w;
    logic signed [JS:0] js_w;
    logic signed [47:0] contrib;
    logic signed [48:0] tot_w;
    logic           cneg;

    kld_mul u_mul
    (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    kld_div #(
        .DVD_W (PW),
        .DVS_W (JS)
    ) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (jm),
        .status   (div_stat),
        .quot     (div_q)
    );

    always_comb
    begin
        x_sel = sel_w_reg ? w_reg : r_reg;
        msb_c = '0;
        for (int i = 0; i < XW; i++)
        begin
            if (x_sel[i])
            begin
                msb_c = 5'(i);
            end
        end
    end

    always_comb
    begin
        r_wide = 41'(in_data.ref_prob);
        w_wide = 41'(in_data.warped_prob);
        r_clip = XW'(r_wide[PROB_FRAC_BITS:0]);
        w_clip = XW'(w_wide[PROB_FRAC_BITS:0]);
        if (r_clip > PROB_ONE)
        begin
            r_clip = PROB_ONE;
        end
        if (w_clip > PROB_ONE)
        begin
            w_clip = PROB_ONE;
        end
    end

    assign jmag = jac_reg[15] ? 16'(-jac_reg) : 16'(jac_reg);
    assign tm   = tp_reg[TP-1] ? TP'(-tp_reg) : TP'(tp_reg);
    assign jm   = js_reg[JS-1] ? JS'(-js_reg) : JS'(js_reg);
    assign bw   = {wt_reg, 4'b0000};
    assign sq   = mul_p[61:30];
    assign cneg = tp_reg[TP-1] != js_reg[JS-1];

    always_comb
    begin
        state_next     = state_reg;
        jac_en_next    = jac_en_reg;
        r_next         = r_reg;
        w_next         = w_reg;
        jac_next       = jac_reg;
        wt_next        = wt_reg;
        ltp_next       = ltp_reg;
        lset_next      = lset_reg;
        sel_w_next     = sel_w_reg;
        m_next         = m_reg;
        msb_next       = msb_reg;
        frac_next      = frac_reg;
        cnt_next       = cnt_reg;
        logr_next      = logr_reg;
        dmag_next      = dmag_reg;
        neg_next       = neg_reg;
        ln_next        = ln_reg;
        t_next         = t_reg;
        tp_next        = tp_reg;
        js_next        = js_reg;
        tot_next       = tot_reg;
        empty_next     = empty_reg;
        plo_next       = plo_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_dvd        = '0;
        logv           = {msb_reg, frac_next};
        rnd            = '0;
        tp_w           = '0;
        js_w           = '0;
        contrib        = '0;
        tot_w          = '0;
        in_stall       = 1'b1;

        if (cfg_valid)
        begin
            jac_en_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    r_next     = r_clip + XW'(1);
                    w_next     = w_clip + XW'(1);
                    jac_next   = jac_en_reg ? in_data.jacobian : JAC_ONE;
                    wt_next    = in_data.timepoint_weight;
                    ltp_next   = in_data.last_of_timepoint;
                    lset_next  = in_data.last_of_set;
                    sel_w_next = 1'b0;
                    if (in_data.in_mask && (in_data.timepoint_weight != 16'd0))
                    begin
                        state_next = ST_LOG_NORM;
                    end
                    else
                    begin
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_LOG_NORM:
            begin
                // mantissa to Q1.30
                m_next     = 31'(x_sel) << (5'd30 - msb_c);
                msb_next   = msb_c;
                frac_next  = '0;
                cnt_next   = '0;
                state_next = ST_LOG_SQ;
            end
            ST_LOG_SQ:
            begin
                mul_a     = {1'b0, m_reg};
                mul_b     = {1'b0, m_reg};
                frac_next = {frac_reg[22:0], sq[31]};
                m_next    = sq[31] ? sq[31:1] : sq[30:0];
                cnt_next  = cnt_reg + 5'd1;
                logv      = {msb_reg, frac_next};
                if (cnt_reg == 5'(LOG_FRAC - 1))
                begin
                    if (!sel_w_reg)
                    begin
                        logr_next  = logv;
                        sel_w_next = 1'b1;
                        state_next = ST_LOG_NORM;
                    end
                    else
                    begin
                        neg_next   = logr_reg < logv;
                        dmag_next  = (logr_reg < logv) ? (logv - logr_reg) : (logr_reg - logv);
                        state_next = ST_LN_MUL;
                    end
                end
            end
            ST_LN_MUL:
            begin
                mul_a      = {3'b000, dmag_reg};
                mul_b      = LN2_Q32;
                rnd        = mul_p + 64'h8000_0000;
                ln_next    = rnd[61:32];
                state_next = ST_REF_MUL;
            end
            ST_REF_MUL:
            begin
                mul_a      = 32'(r_reg);
                mul_b      = {2'b00, ln_reg};
                rnd        = mul_p + (64'd1 << (PROB_FRAC_BITS - 1));
                t_next     = 34'(rnd >> PROB_FRAC_BITS);
                state_next = jac_en_reg ? ST_JAC_MUL : ST_ACCUM;
            end
            ST_JAC_MUL:
            begin
                mul_a      = t_reg[31:0];
                mul_b      = 32'(jmag);
                rnd        = mul_p + 64'd2048;
                t_next     = rnd[45:12];
                neg_next   = neg_reg ^ jac_reg[15];
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                // the term is subtracted, so a negative log adds
                tp_w = neg_reg ? ({tp_reg[TP-1], tp_reg} + (TP+1)'(t_reg))
                               : ({tp_reg[TP-1], tp_reg} - (TP+1)'(t_reg));
                if (tp_w[TP] != tp_w[TP-1])
                begin
                    tp_next = tp_w[TP] ? {1'b1, {(TP-1){1'b0}}} : {1'b0, {(TP-1){1'b1}}};
                end
                else
                begin
                    tp_next = tp_w[TP-1:0];
                end
                js_w = {js_reg[JS-1], js_reg} + {{(JS+1-16){jac_reg[15]}}, jac_reg};
                if (js_w[JS] != js_w[JS-1])
                begin
                    js_next = js_w[JS] ? {1'b1, {(JS-1){1'b0}}} : {1'b0, {(JS-1){1'b1}}};
                end
                else
                begin
                    js_next = js_w[JS-1:0];
                end
                state_next = ST_CLOSE;
            end
            ST_CLOSE:
            begin
                if (ltp_reg || lset_reg)
                begin
                    if ((wt_reg != 16'd0) && (js_reg != '0))
                    begin
                        state_next = ST_PROD_LO;
                    end
                    else
                    begin
                        if (wt_reg != 16'd0)
                        begin
                            empty_next = 1'b1;
                        end
                        state_next = ST_CLEAR;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PROD_LO:
            begin
                mul_a      = tm[31:0];
                mul_b      = 32'(bw);
                plo_next   = mul_p;
                state_next = ST_PROD_HI;
            end
            ST_PROD_HI:
            begin
                mul_a      = 32'(tm[TP-1:32]);
                mul_b      = 32'(bw);
                div_start  = 1'b1;
                div_dvd    = PW'(plo_reg) + (PW'(mul_p) << 32);
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (div_stat.big || div_q[48] || div_q[47])
                    begin
                        contrib = cneg ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                    end
                    else
                    begin
                        contrib = cneg ? -$signed({1'b0, div_q[46:0]}) : $signed({1'b0, div_q[46:0]});
                    end
                    tot_w = {tot_reg[47], tot_reg} + {contrib[47], contrib};
                    if (tot_w[48] != tot_w[47])
                    begin
                        tot_next = tot_w[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                    end
                    else
                    begin
                        tot_next = tot_w[47:0];
                    end
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                tp_next    = '0;
                js_next    = '0;
                state_next = lset_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next.measure_value   = tot_reg;
                    out_next.empty_timepoint = empty_reg;
                    out_valid_next = 1'b1;
                    tot_next       = '0;
                    empty_next     = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            jac_en_reg    <= 1'b0;
            tp_reg        <= '0;
            js_reg        <= '0;
            tot_reg       <= '0;
            empty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            sel_w_reg     <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            jac_en_reg    <= jac_en_next;
            tp_reg        <= tp_next;
            js_reg        <= js_next;
            tot_reg       <= tot_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
            sel_w_reg     <= sel_w_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        w_reg    <= w_next;
        jac_reg  <= jac_next;
        wt_reg   <= wt_next;
        ltp_reg  <= ltp_next;
        lset_reg <= lset_next;
        m_reg    <= m_next;
        msb_reg  <= msb_next;
        frac_reg <= frac_next;
        logr_reg <= logr_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
        ln_reg   <= ln_next;
        t_reg    <= t_next;
        plo_reg  <= plo_next;
        out_reg  <= out_next;
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted but block not busy");

    a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_EMIT))
        else $error("result loaded outside emit");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished with nobody waiting");

endmodule

FILE: rtl/kld_mul.sv
module kld_mul
    import kld_pkg::*;
(
    input  logic [MUL_W-1:0]   a,
    input  logic [MUL_W-1:0]   b,
    output logic [2*MUL_W-1:0] p
);

    // shared unsigned multiplier, the caller registers the product
    assign p = (2*MUL_W)'(a) * (2*MUL_W)'(b);

endmodule

FILE: rtl/kld_div.sv
module kld_div
    import kld_pkg::*;
#(
    parameter int DVD_W = 76,
    parameter int DVS_W = 40
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DVD_W-1:0]     dividend,
    input  logic [DVS_W-1:0]     divisor,
    output kld_div_status_t      status,
    output logic [QUOT_W-1:0]    quot
);

    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [QUOT_W-1:0] q_reg, q_next;
    logic              big_reg, big_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    rem_sh;
    logic              fits;

    always_comb
    begin
        rem_sh    = {rem_reg, dvd_reg[DVD_W-1]};
        fits      = rem_sh >= {1'b0, dvs_reg};
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        big_next  = big_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            q_next    = '0;
            big_next  = 1'b0;
            cnt_next  = CW'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            rem_next = fits ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DVS_W-1:0];
            // quotient beyond the output range only needs to be remembered
            big_next = big_reg | q_reg[QUOT_W-1];
            q_next   = {q_reg[QUOT_W-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        big_reg <= big_next;
    end

    assign status = '{done: done_reg, big: big_reg};
    assign quot   = q_reg;

endmodule
